// ===== rtl/core/ffca_pkg.sv =====
`default_nettype none
package ffca_pkg;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NULL    = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

  localparam logic [31:0] MARKER_NEW    = 32'h1234_5678;
  localparam logic [31:0] MARKER_REUSED = 32'h8765_4321;
  localparam logic [31:0] MARKER_FREED  = 32'hFFFF_FFFF;
  localparam logic [31:0] MARKER_NONE   = 32'h0000_0000;

  localparam logic [1:0] CFG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] CFG_HEAP_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

  localparam logic [31:0] HEAP_BASE_RST    = 32'd0;
  localparam logic [31:0] HEAP_LIMIT_RST   = 32'd1048576;
  localparam logic [7:0]  HEADER_BYTES_RST = 8'd24;

  typedef struct packed {
    logic [31:0] heap_base;
    logic [31:0] heap_limit;
    logic [7:0]  header_bytes;
  } ffca_cfg_t;

  // One table entry: payload size, header offset from the heap base, free flag.
  typedef struct packed {
    logic [23:0] size;
    logic [31:0] offset;
    logic        is_free;
  } ffca_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_addr;
    logic [5:0]  chunk_index;
    logic [31:0] marker;
  } ffca_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffca_table.sv =====
`default_nettype none
module ffca_table #(
  parameter int MAX_CHUNKS = 64,
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  wire                      clk,
  input  wire                      rd_en,
  input  wire [IDX_W-1:0]          rd_addr,
  output ffca_pkg::ffca_entry_t    rd_data,
  input  wire                      wr_en,
  input  wire [IDX_W-1:0]          wr_addr,
  input  ffca_pkg::ffca_entry_t    wr_data
);
  import ffca_pkg::*;

  ffca_entry_t mem [MAX_CHUNKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffca_ctrl.sv =====
`default_nettype none
module ffca_ctrl #(
  parameter int MAX_CHUNKS = 64,
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_type,
  input  wire [23:0]               in_size,
  input  wire [31:0]               in_addr,
  input  ffca_pkg::ffca_cfg_t      cfg,
  output logic                     rd_en,
  output logic [IDX_W-1:0]         rd_addr,
  input  ffca_pkg::ffca_entry_t    rd_data,
  output logic                     wr_en,
  output logic [IDX_W-1:0]         wr_addr,
  output ffca_pkg::ffca_entry_t    wr_data,
  output logic                     res_valid,
  input  wire                      res_ready,
  output ffca_pkg::ffca_res_t      res
);
  import ffca_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic             type_r, type_nxt;
  logic [23:0]      size_r, size_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [24:0]      hs_r, hs_nxt;
  logic [31:0]      basehdr_r, basehdr_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      used_r, used_nxt;
  ffca_res_t        res_r, res_nxt;

  logic             match;
  logic             more;
  logic [32:0]      end_sum;
  logic [IDX_W+5:0] hit_ext;
  logic [CNT_W+5:0] cnt_ext;

  // The free key is the header offset the address must match, so the scan
  // compares one stored field instead of recomputing each payload address.
  assign match = (type_r == REQ_ALLOC) ? (rd_data.is_free && (rd_data.size >= size_r))
                                       : (rd_data.offset == key_r);
  assign more    = (rd_idx_r < count_r);
  assign end_sum = {1'b0, used_r} + {8'b0, hs_r};
  assign hit_ext = {6'b0, cmp_idx_r};
  assign cnt_ext = {6'b0, count_r};

  always_comb begin
    state_nxt   = state_r;
    type_nxt    = type_r;
    size_nxt    = size_r;
    key_nxt     = key_r;
    hs_nxt      = hs_r;
    basehdr_nxt = basehdr_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    count_nxt   = count_r;
    used_nxt    = used_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_r;
    wr_data     = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          type_nxt    = in_type;
          size_nxt    = in_size;
          key_nxt     = in_addr - cfg.heap_base - {24'b0, cfg.header_bytes};
          hs_nxt      = {17'b0, cfg.header_bytes} + {1'b0, in_size};
          basehdr_nxt = cfg.heap_base + {24'b0, cfg.header_bytes};
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          if ((in_type == REQ_ALLOC && in_size == 24'd0) ||
              (in_type == REQ_FREE && in_addr == 32'd0)) begin
            res_nxt   = '{STATUS_NULL, 32'd0, 6'd0, MARKER_NONE};
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b0;
        if (cmp_vld_r && match) begin
          wr_en           = 1'b1;
          wr_data.is_free = (type_r == REQ_FREE);
          res_nxt.status       = STATUS_OK;
          res_nxt.payload_addr = basehdr_r + rd_data.offset;
          res_nxt.chunk_index  = hit_ext[5:0];
          res_nxt.marker       = (type_r == REQ_FREE) ? MARKER_FREED : MARKER_REUSED;
          state_nxt = ST_FINISH;
        end else if (!cmp_vld_r && !more) begin
          if (type_r == REQ_FREE) begin
            res_nxt   = '{STATUS_UNKNOWN, 32'd0, 6'd0, MARKER_NONE};
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_APPEND;
          end
        end else if (more) begin
          rd_en       = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
      end
      ST_APPEND: begin
        if (count_r >= CNT_W'(MAX_CHUNKS) || end_sum > {1'b0, cfg.heap_limit}) begin
          res_nxt = '{STATUS_FULL, 32'd0, 6'd0, MARKER_NONE};
        end else begin
          wr_en           = 1'b1;
          wr_addr         = count_r[IDX_W-1:0];
          wr_data.size    = size_r;
          wr_data.offset  = used_r;
          wr_data.is_free = 1'b0;
          count_nxt       = count_r + 1'b1;
          used_nxt        = end_sum[31:0];
          res_nxt.status       = STATUS_OK;
          res_nxt.payload_addr = basehdr_r + used_r;
          res_nxt.chunk_index  = cnt_ext[5:0];
          res_nxt.marker       = MARKER_NEW;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_FINISH);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      count_r   <= '0;
      used_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      count_r   <= count_nxt;
      used_r    <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r    <= type_nxt;
    size_r    <= size_nxt;
    key_r     <= key_nxt;
    hs_r      <= hs_nxt;
    basehdr_r <= basehdr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_chunk_allocator_top.sv =====
// A zero size or a null free is answered without a scan. Otherwise the table is scanned
// from entry 0 and the first hit answers; a free that misses every entry reports unknown,
// and an allocate that misses appends a new entry at the heap break if there is room.
// One request is handled at a time; a new one is taken only when the control is idle.
// Reset (synchronous, rst_n low) clears the control state, chunk count, heap break and
// registers to their defaults; table contents are not cleared.
`default_nettype none
module first_fit_chunk_allocator_top #(
  parameter int MAX_CHUNKS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,   // req_size[23:0], free_addr[55:24]
  input  wire  [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // payload_addr[31:0], chunk_index[37:32],
                                  // marker[69:38], zero fill[71:70]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import ffca_pkg::*;

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  ffca_cfg_t        cfg_r;
  ffca_res_t        out_res_r;
  logic             out_valid_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  ffca_entry_t      rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ffca_entry_t      wr_data;
  logic             res_valid;
  logic             res_ready;
  ffca_res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_base    <= HEAP_BASE_RST;
      cfg_r.heap_limit   <= HEAP_LIMIT_RST;
      cfg_r.header_bytes <= HEADER_BYTES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:    cfg_r.heap_base    <= cfg_data;
        CFG_HEAP_LIMIT:   cfg_r.heap_limit   <= cfg_data;
        CFG_HEADER_BYTES: cfg_r.header_bytes <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ffca_table #(.MAX_CHUNKS(MAX_CHUNKS)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffca_ctrl #(.MAX_CHUNKS(MAX_CHUNKS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_type   (in_tuser[0]),
    .in_size   (in_tdata[23:0]),
    .in_addr   (in_tdata[55:24]),
    .cfg       (cfg_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register lets the next request start while a result waits.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {2'b00, out_res_r.marker, out_res_r.chunk_index, out_res_r.payload_addr};

endmodule
`default_nettype wire

// ===== test/first_fit_chunk_allocator_top_test.sv =====
`default_nettype none
module first_fit_chunk_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ffca_pkg::*;

  localparam int MAX_CHUNKS  = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        kind;
    logic [23:0] size;
    logic [31:0] addr;
  } heap_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  first_fit_chunk_allocator_top #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted allocator state and register shadows.
  logic [23:0] tbl_size [MAX_CHUNKS];
  logic [31:0] tbl_off [MAX_CHUNKS];
  logic        tbl_free [MAX_CHUNKS];
  int          n_chunks = 0;
  logic [31:0] heap_brk = '0;
  logic [31:0] cur_base = HEAP_BASE_RST;
  logic [31:0] cur_limit = HEAP_LIMIT_RST;
  logic [7:0]  cur_hdr = HEADER_BYTES_RST;

  heap_req_t   req_queue[$];
  ffca_res_t   expected_replies[$];
  int          pushed = 0;
  int          answered = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          cfg_fire = 1'b0;
  bit          calm = 1'b0;
  int          hold_ticket = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          in_gap = 0;

  function automatic logic [31:0] payload_at(int k);
    return cur_base + tbl_off[k] + 32'(cur_hdr);
  endfunction

  function automatic ffca_res_t heap_predict(heap_req_t r);
    ffca_res_t   res;
    logic [32:0] brk_end;
    int          k;
    res = '0;
    if (r.kind == REQ_ALLOC) begin
      if (r.size == 24'd0) begin
        res.status = STATUS_NULL;
        return res;
      end
      for (k = 0; k < n_chunks; k++) begin
        if (tbl_free[k] && tbl_size[k] >= r.size) begin
          tbl_free[k] = 1'b0;
          res.status = STATUS_OK;
          res.payload_addr = payload_at(k);
          res.chunk_index = 6'(k);
          res.marker = MARKER_REUSED;
          return res;
        end
      end
      brk_end = 33'(heap_brk) + 33'(cur_hdr) + 33'(r.size);
      if (n_chunks >= MAX_CHUNKS || brk_end > 33'(cur_limit)) begin
        res.status = STATUS_FULL;
        return res;
      end
      tbl_size[n_chunks] = r.size;
      tbl_off[n_chunks] = heap_brk;
      tbl_free[n_chunks] = 1'b0;
      res.status = STATUS_OK;
      res.payload_addr = payload_at(n_chunks);
      res.chunk_index = 6'(n_chunks);
      res.marker = MARKER_NEW;
      n_chunks++;
      heap_brk = brk_end[31:0];
      return res;
    end
    if (r.addr == 32'd0) begin
      res.status = STATUS_NULL;
      return res;
    end
    // The lowest entry with a matching payload address wins.
    for (k = 0; k < n_chunks; k++) begin
      if (payload_at(k) == r.addr) begin
        tbl_free[k] = 1'b1;
        res.status = STATUS_OK;
        res.payload_addr = r.addr;
        res.chunk_index = 6'(k);
        res.marker = MARKER_FREED;
        return res;
      end
    end
    res.status = STATUS_UNKNOWN;
    return res;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random request drawn against the predicted table, which may lag by the
  // requests still in flight. Entries are never removed, so known payload
  // addresses stay valid until the next register change.
  function automatic heap_req_t make_req(int alloc_pct);
    heap_req_t r;
    int        roll;
    int        pick;
    r.kind = REQ_ALLOC;
    r.size = 24'($urandom);
    r.addr = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        r.size = 24'($urandom_range(1, 256));
      end else if (pick < 9) begin
        r.size = 24'($urandom_range(1, 65535));
      end
    end else if (roll < 92 && n_chunks > 0) begin
      r.kind = REQ_FREE;
      r.addr = payload_at($urandom_range(0, n_chunks - 1));
    end else if (roll < 97) begin
      r.kind = REQ_FREE;
    end else begin
      r.kind = 1'($urandom_range(0, 1));
      r.size = 24'd0;
      r.addr = 32'd0;
    end
    return r;
  endfunction

  always @(negedge clk) begin : drive_requests
    heap_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        nxt = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.addr, nxt.size};
        in_tuser <= nxt.kind;
        in_gap = calm ? 0 : idle_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = calm ? 0 : idle_gap();
    end
  end

  always @(posedge clk) begin : watch_bus
    heap_req_t got;
    ffca_res_t want;
    ffca_res_t seen;
    in_fire = in_tvalid && in_tready;
    out_fire = out_tvalid && out_tready;
    cfg_fire = cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_fire) begin
        case (cfg_index)
          CFG_HEAP_BASE: begin
            cur_base = cfg_data;
          end
          CFG_HEAP_LIMIT: begin
            cur_limit = cfg_data;
          end
          CFG_HEADER_BYTES: begin
            cur_hdr = cfg_data[7:0];
          end
          default: begin
          end
        endcase
      end
      if (out_fire) begin
        answered++;
        seen.status = out_tuser;
        seen.payload_addr = out_tdata[31:0];
        seen.chunk_index = out_tdata[37:32];
        seen.marker = out_tdata[69:38];
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding: status %0d addr %h",
                 seen.status, seen.payload_addr);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (seen.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, seen.status);
            fail_count++;
          end
          if (seen.payload_addr !== want.payload_addr) begin
            $error("payload_addr expected %h got %h", want.payload_addr, seen.payload_addr);
            fail_count++;
          end
          if (seen.chunk_index !== want.chunk_index) begin
            $error("chunk_index expected %0d got %0d", want.chunk_index, seen.chunk_index);
            fail_count++;
          end
          if (seen.marker !== want.marker) begin
            $error("marker expected %h got %h", want.marker, seen.marker);
            fail_count++;
          end
        end
      end
      if (in_fire) begin
        got.kind = in_tuser[0];
        got.size = in_tdata[23:0];
        got.addr = in_tdata[55:24];
        expected_replies.push_back(heap_predict(got));
      end
      if (in_fire || out_fire || cfg_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (answered != pushed) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] base, logic [31:0] limit, logic [7:0] hdr);
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_LIMIT, limit);
    write_reg(CFG_HEADER_BYTES, {24'd0, hdr});
  endtask

  // Directed requests run one at a time so that addresses come from settled state.
  task automatic request_and_wait(logic kind, logic [23:0] size, logic [31:0] addr);
    heap_req_t r;
    r.kind = kind;
    r.size = size;
    r.addr = addr;
    req_queue.push_back(r);
    pushed++;
    wait_idle();
  endtask

  task automatic run_phase(int count, int alloc_pct);
    int j;
    for (j = 0; j < count; j++) begin
      while (req_queue.size() >= 2) @(negedge clk);
      req_queue.push_back(make_req(alloc_pct));
      pushed++;
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first payload lands exactly on the wrap to address zero.
    set_config(32'hFFFF_FFE8, HEAP_LIMIT_RST, HEADER_BYTES_RST);
    request_and_wait(REQ_ALLOC, 24'd16, 32'd0);
    request_and_wait(REQ_FREE, 24'd0, 32'd0);
    request_and_wait(REQ_ALLOC, 24'd0, 32'd0);
    request_and_wait(REQ_ALLOC, 24'hFF_FFFF, 32'd0);
    request_and_wait(REQ_ALLOC, 24'd1, 32'd0);
    request_and_wait(REQ_ALLOC, 24'd1000, 32'd0);
    request_and_wait(REQ_FREE, 24'hFF_FFFF, payload_at(1));
    request_and_wait(REQ_FREE, 24'd0, payload_at(1));
    request_and_wait(REQ_ALLOC, 24'd1, 32'd0);
    request_and_wait(REQ_FREE, 24'd0, payload_at(2));
    request_and_wait(REQ_ALLOC, 24'd500, 32'd0);
    request_and_wait(REQ_FREE, 24'd0, 32'hFFFF_FFFF);
    // Fill the heap to the last byte, then overflow it by one.
    request_and_wait(REQ_ALLOC, 24'(cur_limit - heap_brk - 32'(cur_hdr)), 32'd0);
    request_and_wait(REQ_ALLOC, 24'd1, 32'd0);

    set_config(32'h0000_0000, 32'hFFFF_FFFF, 8'd255);
    request_and_wait(REQ_ALLOC, 24'd3, 32'd0);
    request_and_wait(REQ_FREE, 24'd0, payload_at(3));
    request_and_wait(REQ_ALLOC, 24'hFF_FFFF, 32'd0);

    // A limit below the break blocks appends while reuse still works.
    set_config(32'h0000_0000, 32'h0000_0000, 8'd0);
    request_and_wait(REQ_ALLOC, 24'd2, 32'd0);
    request_and_wait(REQ_ALLOC, 24'd7, 32'd0);
    request_and_wait(REQ_FREE, 24'd0, 32'h8000_0001);

    set_config(32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
    run_phase(130, 65);

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    run_phase(130, 45);

    set_config($urandom, 32'h0000_0000, 8'($urandom_range(0, 255)));
    run_phase(120, 45);

    calm = 1'b1;
    set_config($urandom, heap_brk + 32'($urandom_range(1000, 100000)),
               8'($urandom_range(0, 255)));
    run_phase(140, 50);
    calm = 1'b0;

    // The receiver stalls for a long stretch while requests keep coming.
    set_config(HEAP_BASE_RST, HEAP_LIMIT_RST, HEADER_BYTES_RST);
    hold_ticket++;
    run_phase(130, 50);

    set_config($urandom, $urandom, 8'($urandom_range(0, 255)));
    run_phase(130, 50);

    wait_idle();
    repeat (80) @(negedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
